>>> src/plgc_pkg.sv
// Package: shared types and constants for the power-loss grace controller.
`timescale 1ns / 1ps

package plgc_pkg;

  // Power state codes
  localparam logic [2:0] ST_EXTERNAL    = 3'd0;
  localparam logic [2:0] ST_DEB_LOSS    = 3'd1;
  localparam logic [2:0] ST_GRACE       = 3'd2;
  localparam logic [2:0] ST_DEB_RESTORE = 3'd3;
  localparam logic [2:0] ST_COMMITTED   = 3'd4;

  // Event / acknowledge codes
  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_REMOVED  = 2'd1;
  localparam logic [1:0] ACT_RESTORED = 2'd2;
  localparam logic [1:0] ACT_COMMIT   = 2'd3;

  // Event sequence codes
  localparam logic [1:0] SEQ_NONE   = 2'd0;
  localparam logic [1:0] SEQ_FIRST  = 2'd1;
  localparam logic [1:0] SEQ_SECOND = 2'd2;

  // Item mode
  localparam logic MODE_OBSERVE = 1'b0;
  localparam logic MODE_ACK     = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_COMMIT   = 2'd1;
  localparam logic [1:0] REG_ABS_OFF  = 2'd2;

  // Fallback timings in ms
  localparam logic [31:0] DEF_DEBOUNCE = 32'd500;
  localparam logic [31:0] DEF_COMMIT   = 32'd30000;
  localparam logic [31:0] DEF_ABS_OFF  = 32'd60000;

  // x / 1000 == (x * DIV_RECIP) >> DIV_SHIFT, exact for every 32-bit x
  localparam logic [31:0] DIV_RECIP = 32'h10624DD3;
  localparam int          DIV_SHIFT = 38;
  localparam int          SEC_W     = 23;

  typedef struct packed {
    logic [31:0] debounce_time;
    logic [31:0] commit_time;
    logic [31:0] absolute_off_time;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic        adapter_on;
    logic [31:0] now_time;
    logic [1:0]  ack_action;
  } item_t;

  typedef struct packed {
    logic [2:0]  power_state;
    logic        grace_active;
    logic        shutdown_done;
    logic [31:0] incident_number;
    logic [1:0]  pending_action;
    logic [1:0]  action_sequence;
    logic        ack_ok;
  } hdr_t;

  typedef struct packed {
    hdr_t        hdr;
    logic [31:0] now_time;
    logic [31:0] grace_start;
    logic [31:0] abs_off;
  } fsm_out_t;

  typedef struct packed {
    hdr_t             hdr;
    logic [SEC_W-1:0] elapsed_sec;
    logic [SEC_W-1:0] remain_sec;
  } result_t;

endpackage

>>> src/plgc_fsm.sv
// Power state machine, incident tracking and event flags, one item per cycle unless stalled.
`timescale 1ns / 1ps

module plgc_fsm import plgc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  item_t    item_i,
  input  cfg_t     cfg_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fsm_out_t out_o
);

  logic [2:0]  state_q, state_d;
  logic [31:0] trans_start_q, trans_start_d;
  logic [31:0] grace_start_q, grace_start_d;
  logic [31:0] cur_inc_q, cur_inc_d;
  logic [31:0] prev_inc_q, prev_inc_d;
  logic        removed_q, removed_d;
  logic        restored_q, restored_d;
  logic        commit_q, commit_d;
  logic        valid_q;
  fsm_out_t    out_q, out_d;

  logic        timing_ok;
  logic [31:0] eff_deb, eff_commit, eff_abs;
  logic [31:0] since_trans, since_grace, inc_start, inc_base, inc_id;
  logic        ack_ok;
  logic        fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Fall back to all defaults unless debounce is nonzero and the three timings strictly ascend
  assign timing_ok = (cfg_i.debounce_time != 32'd0) &&
                     (cfg_i.commit_time > cfg_i.debounce_time) &&
                     (cfg_i.absolute_off_time > cfg_i.commit_time);
  assign eff_deb    = timing_ok ? cfg_i.debounce_time     : DEF_DEBOUNCE;
  assign eff_commit = timing_ok ? cfg_i.commit_time       : DEF_COMMIT;
  assign eff_abs    = timing_ok ? cfg_i.absolute_off_time : DEF_ABS_OFF;

  assign since_trans = item_i.now_time - trans_start_q;
  assign since_grace = item_i.now_time - grace_start_q;
  assign inc_start   = trans_start_q + eff_deb;
  assign inc_base    = (inc_start == 32'd0) ? 32'd1 : inc_start;
  assign inc_id      = (inc_base != prev_inc_q) ? inc_base :
                       (inc_base == 32'hFFFF_FFFF) ? 32'd1 : inc_base + 32'd1;

  always_comb begin
    state_d       = state_q;
    trans_start_d = trans_start_q;
    grace_start_d = grace_start_q;
    cur_inc_d     = cur_inc_q;
    prev_inc_d    = prev_inc_q;
    removed_d     = removed_q;
    restored_d    = restored_q;
    commit_d      = commit_q;
    ack_ok        = 1'b0;
    if (item_i.mode == MODE_OBSERVE) begin
      case (state_q)
        ST_EXTERNAL: begin
          if (!item_i.adapter_on) begin
            state_d       = ST_DEB_LOSS;
            trans_start_d = item_i.now_time;
          end
        end
        ST_DEB_LOSS: begin
          if (item_i.adapter_on) begin
            state_d = ST_EXTERNAL;
          end else if (since_trans >= eff_deb) begin
            // loss accepted: open an incident dated at debounce end
            state_d       = ST_GRACE;
            grace_start_d = inc_start;
            cur_inc_d     = inc_id;
            prev_inc_d    = inc_id;
            removed_d     = 1'b1;
            restored_d    = 1'b0;
            commit_d      = 1'b0;
          end
        end
        ST_GRACE: begin
          if (since_grace >= eff_commit) begin
            state_d  = ST_COMMITTED;
            commit_d = 1'b1;
          end else if (item_i.adapter_on) begin
            state_d       = ST_DEB_RESTORE;
            trans_start_d = item_i.now_time;
          end
        end
        ST_DEB_RESTORE: begin
          if (since_grace >= eff_commit) begin
            state_d  = ST_COMMITTED;
            commit_d = 1'b1;
          end else if (!item_i.adapter_on) begin
            state_d = ST_GRACE;
          end else if (since_trans >= eff_deb) begin
            state_d    = ST_EXTERNAL;
            restored_d = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (item_i.ack_action)
        ACT_REMOVED: begin
          if (removed_q) begin
            removed_d = 1'b0;
            ack_ok    = 1'b1;
          end
        end
        ACT_RESTORED: begin
          if (restored_q) begin
            restored_d    = 1'b0;
            cur_inc_d     = 32'd0;
            grace_start_d = 32'd0;
            ack_ok        = 1'b1;
          end
        end
        ACT_COMMIT: begin
          if (commit_q) begin
            commit_d = 1'b0;
            ack_ok   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d.hdr.power_state     = state_d;
    out_d.hdr.grace_active    = state_d inside {ST_GRACE, ST_DEB_RESTORE, ST_COMMITTED};
    out_d.hdr.shutdown_done   = (state_d == ST_COMMITTED);
    out_d.hdr.incident_number = cur_inc_d;
    out_d.hdr.ack_ok          = ack_ok;
    if (commit_d) begin
      out_d.hdr.pending_action  = ACT_COMMIT;
      out_d.hdr.action_sequence = SEQ_SECOND;
    end else if (removed_d) begin
      out_d.hdr.pending_action  = ACT_REMOVED;
      out_d.hdr.action_sequence = SEQ_FIRST;
    end else if (restored_d) begin
      out_d.hdr.pending_action  = ACT_RESTORED;
      out_d.hdr.action_sequence = SEQ_SECOND;
    end else begin
      out_d.hdr.pending_action  = ACT_NONE;
      out_d.hdr.action_sequence = SEQ_NONE;
    end
    out_d.now_time    = item_i.now_time;
    out_d.grace_start = grace_start_d;
    out_d.abs_off     = eff_abs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_EXTERNAL;
      trans_start_q <= 32'd0;
      grace_start_q <= 32'd0;
      cur_inc_q     <= 32'd0;
      prev_inc_q    <= 32'd0;
      removed_q     <= 1'b0;
      restored_q    <= 1'b0;
      commit_q      <= 1'b0;
      valid_q       <= 1'b0;
    end else begin
      if (fire) begin
        state_q       <= state_d;
        trans_start_q <= trans_start_d;
        grace_start_q <= grace_start_d;
        cur_inc_q     <= cur_inc_d;
        prev_inc_q    <= prev_inc_d;
        removed_q     <= removed_d;
        restored_q    <= restored_d;
        commit_q      <= commit_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

>>> src/plgc_time.sv
// Elapsed and remaining seconds: difference, reciprocal multiply, round and select.
`timescale 1ns / 1ps

module plgc_time import plgc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fsm_out_t in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_o
);

  // Difference stage
  logic        v2_q;
  hdr_t        hdr2_q;
  logic [31:0] el2_q, rem2_q;
  logic        has_el2_q, has_rem2_q;
  logic [31:0] el_d;

  // Multiply stage
  logic             v3_q;
  hdr_t             hdr3_q;
  logic [SEC_W-1:0] q_el3_q, q_rem3_q;
  logic             has_el3_q, has_rem3_q;
  logic [63:0]      prod_el, prod_rem;

  // Result stage
  logic    vo_q;
  result_t res_q;

  logic rdy_o, rdy_3, rdy_2;

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy_3      = !v3_q || rdy_o;
  assign rdy_2      = !v2_q || rdy_3;
  assign in_ready_o = rdy_2;

  assign el_d     = in_i.now_time - in_i.grace_start;
  assign prod_el  = 64'(el2_q) * 64'(DIV_RECIP);
  assign prod_rem = 64'(rem2_q) * 64'(DIV_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_2) v2_q <= in_valid_i;
      if (rdy_3) v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_2) begin
      hdr2_q     <= in_i.hdr;
      el2_q      <= el_d;
      // ceil(d / 1000) taken as floor((d - 1) / 1000) + 1, d nonzero here
      rem2_q     <= in_i.abs_off - el_d - 32'd1;
      has_el2_q  <= (in_i.hdr.incident_number != 32'd0);
      has_rem2_q <= (in_i.hdr.incident_number != 32'd0) && (el_d < in_i.abs_off);
    end
    if (v2_q && rdy_3) begin
      hdr3_q     <= hdr2_q;
      q_el3_q    <= prod_el[DIV_SHIFT +: SEC_W];
      q_rem3_q   <= prod_rem[DIV_SHIFT +: SEC_W];
      has_el3_q  <= has_el2_q;
      has_rem3_q <= has_rem2_q;
    end
    if (v3_q && rdy_o) begin
      res_q.hdr         <= hdr3_q;
      res_q.elapsed_sec <= has_el3_q ? q_el3_q : '0;
      res_q.remain_sec  <= has_rem3_q ? q_rem3_q + SEC_W'(1) : '0;
    end
  end

  assign out_valid_o = vo_q;
  assign out_o       = res_q;

endmodule

>>> src/power_loss_grace_controller_top.sv
// Top level: stream ports, config registers, input register and the two engines.
// Path: the input register loads on the input transfer; then the state machine stage,
//   difference stage, multiply stage and result register follow in that order.
// Throughput: one item per cycle without back-pressure; only the FSM closes a loop.
// Reset: async active low; state external, no incident, flags clear, timings at defaults.
`timescale 1ns / 1ps

module power_loss_grace_controller_top import plgc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [0] adapter_on, [32:1] now_time, [34:33] ack_action
  input  logic        s_axis_tuser,   // [0] mode
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] power_state, [3] grace_active, [4] shutdown_done, [36:5] incident_number,
  // [38:37] pending_action, [40:39] action_sequence, [63:41] elapsed_sec,
  // [86:64] remain_sec, [87] ack_ok
  output logic [87:0] m_axis_tdata,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t     cfg_q;
  logic     s0_valid_q;
  item_t    s0_item_q;
  logic     s0_ready;
  logic     fsm_in_ready;
  logic     fsm_valid;
  fsm_out_t fsm_out;
  logic     tm_ready;
  result_t  res;

  // Take config only while the input register, state machine output and result are empty
  assign cfg_ready_o = !s0_valid_q && !fsm_valid && tm_ready && !m_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time     <= DEF_DEBOUNCE;
      cfg_q.commit_time       <= DEF_COMMIT;
      cfg_q.absolute_off_time <= DEF_ABS_OFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DEBOUNCE: cfg_q.debounce_time     <= cfg_data_i;
        REG_COMMIT:   cfg_q.commit_time       <= cfg_data_i;
        REG_ABS_OFF:  cfg_q.absolute_off_time <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Input register: accept a new transfer when empty or when the state machine drains it
  assign s0_ready      = !s0_valid_q || fsm_in_ready;
  assign s_axis_tready = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s0_ready) begin
      s0_item_q.mode       <= s_axis_tuser;
      s0_item_q.adapter_on <= s_axis_tdata[0];
      s0_item_q.now_time   <= s_axis_tdata[32:1];
      s0_item_q.ack_action <= s_axis_tdata[34:33];
    end
  end

  // State machine: advances once per item as the item leaves the input register
  plgc_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_valid_q),
    .in_ready_o  (fsm_in_ready),
    .item_i      (s0_item_q),
    .cfg_i       (cfg_q),
    .out_valid_o (fsm_valid),
    .out_ready_i (tm_ready),
    .out_o       (fsm_out)
  );

  // Seconds arithmetic and the result register
  plgc_time u_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fsm_valid),
    .in_ready_o  (tm_ready),
    .in_i        (fsm_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {res.hdr.ack_ok, res.remain_sec, res.elapsed_sec,
                         res.hdr.action_sequence, res.hdr.pending_action,
                         res.hdr.incident_number, res.hdr.shutdown_done,
                         res.hdr.grace_active, res.hdr.power_state};

endmodule

>>> src/plgc_checker.sv
// Port-level checker for the power-loss grace controller, with its bind.
`timescale 1ns / 1ps

module plgc_checker import plgc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Shutdown flag and grace flag follow the reported state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tdata[2:0] == ST_COMMITTED)) &&
      (m_axis_tdata[3] == ((m_axis_tdata[2:0] == ST_GRACE) ||
                           (m_axis_tdata[2:0] == ST_DEB_RESTORE) ||
                           (m_axis_tdata[2:0] == ST_COMMITTED))))
    else $error("state flags inconsistent");

  // Without an open incident there are no seconds to report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[36:5] == 32'd0) |->
      (m_axis_tdata[63:41] == '0) && (m_axis_tdata[86:64] == '0))
    else $error("seconds reported without incident");

  // Sequence is zero exactly when nothing is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[40:39] == SEQ_NONE) ==
                       (m_axis_tdata[38:37] == ACT_NONE)))
    else $error("pending action and sequence disagree");

endmodule

bind power_loss_grace_controller_top plgc_checker u_plgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
